### sv/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int POS_FRAC_BITS = 16;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int MAG_W   = POS_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int CW      = POS_W + 4;
    localparam int AW      = 35;
    localparam int HEAD_W  = 16;
    localparam int THR_W   = 15;
    localparam int ANG_SHIFT = 17;
    localparam int KINV_W  = 29;
    localparam int KINV_SHIFT = 29;
    localparam int LAT_W   = 34;
    localparam int LMAG_W  = LAT_W - 1;
    localparam int Q_W     = 31;
    localparam int NUM_W   = POS_W + LMAG_W + POS_FRAC_BITS + 1;
    localparam int REM_W   = (NUM_W > SUM_W + Q_W) ? NUM_W : SUM_W + Q_W;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W   = 32;

    localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic [KINV_W-1:0]    KINV_Q29    = 29'd326016437;
    localparam logic [Q_W-1:0]       RATE_MAX    = '1;

    localparam logic [1:0] ACT_HARD_POS = 2'd0;
    localparam logic [1:0] ACT_HARD_NEG = 2'd1;
    localparam logic [1:0] ACT_PURSUIT  = 2'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE_X,
        REG_BASE_Y,
        REG_RANGE_LIMIT,
        REG_TURN_THRESHOLD,
        REG_MAX_TURN_RATE,
        REG_MAX_SPEED,
        REG_TURN_SPEED
    } reg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic [HEAD_W-1:0]       own_heading;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
    } in_t;

    typedef struct packed {
        logic [31:0]        linear_speed;
        logic signed [31:0] angular_rate;
        logic [1:0]         action;
        logic               going_to_base;
        logic               rate_saturated;
    } out_t;

    typedef struct packed {
        logic signed [POS_W-1:0] base_x;
        logic signed [POS_W-1:0] base_y;
        logic [31:0]             range_limit;
        logic [THR_W-1:0]        turn_threshold;
        logic [30:0]             max_turn_rate;
        logic [31:0]             max_speed;
        logic [31:0]             turn_speed;
    } cfg_t;

    typedef struct packed {
        logic                     to_base;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [AW-1:0]     angle;
    } front_t;

    typedef struct packed {
        logic                     to_base;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [CW-1:0]     ly;
        logic signed [AW-1:0]     err;
    } cordic_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [AW-1:0] atan_step(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0: r = 35'sd843314857;
            1: r = 35'sd497837829;
            2: r = 35'sd263043837;
            3: r = 35'sd133525159;
            4: r = 35'sd67021687;
            5: r = 35'sd33543516;
            6: r = 35'sd16775851;
            7: r = 35'sd8388437;
            8: r = 35'sd4194283;
            9: r = 35'sd2097149;
            default: r = (i <= 30) ? AW'(64'sd1 <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

### sv/pure_pursuit_steering_top.sv
`timescale 1ns / 1ps
// Pure pursuit steering, one command per position beat.
// Input channel s_*: own position and heading with the selected target's
// position, one beat per update. Result channel m_*: speed, signed turn rate,
// action code, the going-to-base flag and the saturation flag.
// Configuration channel cfg_*: cfg_index selects the register (base x, base
// y, range limit, turn threshold, maximum turn rate, pursuit speed, hard turn
// speed in that order), cfg_data carries the value; cfg_ready is always high
// and writes to unused indexes are dropped. Write only while the block is idle.
// From acceptance to m_valid a beat passes four front stages for the range test,
// two iteration chains of the CORDIC (sixteen iterations each by default), and 31
// restoring division stages for the turn rate. A new beat can be taken in every
// cycle while the skid register is free.
// Reset clears the configuration registers to zero and empties the pipeline.
// When the receiver stalls, the result waits in the output register and one
// more beat is caught in a skid register; the pipeline then holds and s_ready
// falls until the receiver takes a beat.
module pure_pursuit_steering_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pps_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pps_pkg::out_t                m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pps_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]    cfg_data
);
    import pps_pkg::*;

    cfg_t    cfg_reg;
    logic    adv;
    logic    f_valid, c_valid, d_valid;
    front_t  f_data;
    cordic_t c_data;
    out_t    d_data;
    logic    push, pop;
    logic    out_v_reg, skid_v_reg;
    out_t    out_reg, skid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_BASE_X:         cfg_reg.base_x         <= cfg_data;
                REG_BASE_Y:         cfg_reg.base_y         <= cfg_data;
                REG_RANGE_LIMIT:    cfg_reg.range_limit    <= cfg_data;
                REG_TURN_THRESHOLD: cfg_reg.turn_threshold <= cfg_data[THR_W-1:0];
                REG_MAX_TURN_RATE:  cfg_reg.max_turn_rate  <= cfg_data[30:0];
                REG_MAX_SPEED:      cfg_reg.max_speed      <= cfg_data;
                REG_TURN_SPEED:     cfg_reg.turn_speed     <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the skid register is free.
    assign adv     = !skid_v_reg;
    assign s_ready = adv;

    pps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    pps_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (c_valid),
        .out_data  (c_data)
    );

    pps_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (c_valid),
        .in_data   (c_data),
        .cfg       (cfg_reg),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    assign push = d_valid && adv;
    assign pop  = out_v_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= push;
            end else begin
                out_v_reg  <= push;
            end
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
        if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= d_data;
            end else begin
                out_reg  <= d_data;
            end
        end else if (push) begin
            skid_reg <= d_data;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

### sv/pps_front.sv
`timescale 1ns / 1ps
module pps_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  pps_pkg::in_t    in_data,
    input  pps_pkg::cfg_t   cfg,
    output logic            out_valid,
    output pps_pkg::front_t out_data
);
    import pps_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    in_t  item1_reg, item2_reg, item3_reg;
    logic signed [DIFF_W-1:0] ex, ey;
    logic [MAG_W-1:0] mx_next, my_next, mx_reg, my_reg;
    logic signed [AW-1:0] h_raw, h_red, h_next, h2_reg, h3_reg;
    logic [SQ_W-1:0] sx_next, sy_next, r2_next, sx_reg, sy_reg, r2_reg;
    logic [SUM_W-1:0] tb;
    logic signed [DIFF_W-1:0] gx, gy;
    front_t f_next, f_reg;

    // Target offset from the base and heading reduction.
    always_comb begin
        ex = DIFF_W'(item1_reg.target_x) - DIFF_W'(cfg.base_x);
        ey = DIFF_W'(item1_reg.target_y) - DIFF_W'(cfg.base_y);
        mx_next = ex[DIFF_W-1] ? MAG_W'(-ex) : MAG_W'(ex);
        my_next = ey[DIFF_W-1] ? MAG_W'(-ey) : MAG_W'(ey);
        h_raw = AW'({1'b0, item1_reg.own_heading, {ANG_SHIFT{1'b0}}});
        h_red = (h_raw >= TWO_PI_Q30) ? h_raw - TWO_PI_Q30 : h_raw;
        h_next = (h_red > PI_Q30) ? h_red - TWO_PI_Q30 : h_red;
    end

    always_comb begin
        sx_next = SQ_W'(mx_reg) * SQ_W'(mx_reg);
        sy_next = SQ_W'(my_reg) * SQ_W'(my_reg);
        r2_next = SQ_W'(cfg.range_limit) * SQ_W'(cfg.range_limit);
    end

    // Range test, goal selection and offset to the goal.
    always_comb begin
        tb = SUM_W'(sx_reg) + SUM_W'(sy_reg);
        f_next.to_base = tb > SUM_W'(r2_reg);
        gx = f_next.to_base ? DIFF_W'(cfg.base_x) : DIFF_W'(item3_reg.target_x);
        gy = f_next.to_base ? DIFF_W'(cfg.base_y) : DIFF_W'(item3_reg.target_y);
        f_next.dx = gx - DIFF_W'(item3_reg.own_x);
        f_next.dy = gy - DIFF_W'(item3_reg.own_y);
        f_next.angle = -h3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (adv) begin
            item1_reg <= in_data;
            item2_reg <= item1_reg;
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            h2_reg    <= h_next;
            item3_reg <= item2_reg;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            r2_reg    <= r2_next;
            h3_reg    <= h2_reg;
            f_reg     <= f_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = f_reg;

endmodule

### sv/pps_cordic.sv
`timescale 1ns / 1ps
module pps_cordic (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  pps_pkg::front_t  in_data,
    output logic             out_valid,
    output pps_pkg::cordic_t out_data
);
    import pps_pkg::*;

    localparam int N = CORDIC_STEPS;

    // Rotation by minus the heading, one iteration per stage.
    logic                 rv_reg  [N+1];
    front_t               rf_reg  [N+1];
    logic signed [CW-1:0] rx_reg  [N+1];
    logic signed [CW-1:0] ry_reg  [N+1];
    logic signed [AW-1:0] ra_reg  [N+1];
    logic signed [CW-1:0] rx_next [N+1];
    logic signed [CW-1:0] ry_next [N+1];
    logic signed [AW-1:0] ra_next [N+1];

    // Vectoring of the rotated offset to get the bearing error.
    logic                 vv_reg  [N+1];
    front_t               vf_reg  [N+1];
    logic signed [CW-1:0] vly_reg [N+1];
    logic                 vzero_reg [N+1];
    logic signed [CW-1:0] vx_reg  [N+1];
    logic signed [CW-1:0] vy_reg  [N+1];
    logic signed [AW-1:0] vz_reg  [N+1];
    logic signed [CW-1:0] vx_next [N+1];
    logic signed [CW-1:0] vy_next [N+1];
    logic signed [AW-1:0] vz_next [N+1];
    logic                 zero_next;

    always_comb begin
        if (in_data.angle > HALF_PI_Q30) begin
            rx_next[0] = -CW'(in_data.dy);
            ry_next[0] = CW'(in_data.dx);
            ra_next[0] = in_data.angle - HALF_PI_Q30;
        end else if (in_data.angle < -HALF_PI_Q30) begin
            rx_next[0] = CW'(in_data.dy);
            ry_next[0] = -CW'(in_data.dx);
            ra_next[0] = in_data.angle + HALF_PI_Q30;
        end else begin
            rx_next[0] = CW'(in_data.dx);
            ry_next[0] = CW'(in_data.dy);
            ra_next[0] = in_data.angle;
        end
        for (int i = 0; i < N; i++) begin
            if (!ra_reg[i][AW-1]) begin
                rx_next[i+1] = rx_reg[i] - (ry_reg[i] >>> i);
                ry_next[i+1] = ry_reg[i] + (rx_reg[i] >>> i);
                ra_next[i+1] = ra_reg[i] - atan_step(i);
            end else begin
                rx_next[i+1] = rx_reg[i] + (ry_reg[i] >>> i);
                ry_next[i+1] = ry_reg[i] - (rx_reg[i] >>> i);
                ra_next[i+1] = ra_reg[i] + atan_step(i);
            end
        end
    end

    always_comb begin
        zero_next = (rx_reg[N] == '0) && (ry_reg[N] == '0);
        if (rx_reg[N][CW-1]) begin
            if (!ry_reg[N][CW-1]) begin
                vx_next[0] = ry_reg[N];
                vy_next[0] = -rx_reg[N];
                vz_next[0] = HALF_PI_Q30;
            end else begin
                vx_next[0] = -ry_reg[N];
                vy_next[0] = rx_reg[N];
                vz_next[0] = -HALF_PI_Q30;
            end
        end else begin
            vx_next[0] = rx_reg[N];
            vy_next[0] = ry_reg[N];
            vz_next[0] = '0;
        end
        for (int i = 0; i < N; i++) begin
            if (!vy_reg[i][CW-1]) begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + atan_step(i);
            end else begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - atan_step(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= N; i++) begin
                rv_reg[i] <= 1'b0;
                vv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            rv_reg[0] <= in_valid;
            vv_reg[0] <= rv_reg[N];
            for (int i = 1; i <= N; i++) begin
                rv_reg[i] <= rv_reg[i-1];
                vv_reg[i] <= vv_reg[i-1];
            end
        end
        if (adv) begin
            rf_reg[0]    <= in_data;
            vf_reg[0]    <= rf_reg[N];
            vly_reg[0]   <= ry_reg[N];
            vzero_reg[0] <= zero_next;
            for (int i = 1; i <= N; i++) begin
                rf_reg[i]    <= rf_reg[i-1];
                vf_reg[i]    <= vf_reg[i-1];
                vly_reg[i]   <= vly_reg[i-1];
                vzero_reg[i] <= vzero_reg[i-1];
            end
            for (int i = 0; i <= N; i++) begin
                rx_reg[i] <= rx_next[i];
                ry_reg[i] <= ry_next[i];
                ra_reg[i] <= ra_next[i];
                vx_reg[i] <= vx_next[i];
                vy_reg[i] <= vy_next[i];
                vz_reg[i] <= vz_next[i];
            end
        end
    end

    // With own position on the goal the bearing error is taken as zero.
    always_comb begin
        out_data.to_base = vf_reg[N].to_base;
        out_data.dx      = vf_reg[N].dx;
        out_data.dy      = vf_reg[N].dy;
        out_data.ly      = vly_reg[N];
        out_data.err     = vzero_reg[N] ? '0 : vz_reg[N];
    end

    assign out_valid = vv_reg[N];

endmodule

### sv/pps_div.sv
`timescale 1ns / 1ps
module pps_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  pps_pkg::cordic_t in_data,
    input  pps_pkg::cfg_t    cfg,
    output logic             out_valid,
    output pps_pkg::out_t    out_data
);
    import pps_pkg::*;

    localparam int LO_W   = CW / 2;
    localparam int HI_W   = CW - LO_W;
    localparam int PLO_W  = LO_W + KINV_W;
    localparam int PHI_W  = HI_W + KINV_W + 1;
    localparam int PROD_W = CW + KINV_W + 1;
    localparam int LM_LO  = (LMAG_W + 1) / 2;
    localparam int LM_HI  = LMAG_W - LM_LO;
    localparam int PPL_W  = 32 + LM_LO;
    localparam int PPH_W  = 32 + LM_HI;

    typedef struct packed {
        logic pos;
        logic neg;
        logic to_base;
    } turn_t;

    typedef struct packed {
        turn_t            turn;
        logic             lat_neg;
        logic             dz;
        logic             big;
        logic [SUM_W-1:0] d;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } div_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    turn_t t1_next, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [AW-1:0] thr;
    logic [MAG_W-1:0] ax, ay;
    logic [SQ_W-1:0] sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [PLO_W-1:0] plo_next, plo_reg;
    logic signed [PHI_W-1:0] phi_next, phi_reg;
    logic signed [PROD_W-1:0] prod, prod_sh;
    logic signed [LAT_W-1:0] lat_next, lat_reg;
    logic [SUM_W-1:0] d_next, d2_reg, d3_reg, d4_reg;
    logic [LMAG_W-1:0] lmag_next, lmag_reg;
    logic lneg3_reg, lneg4_reg;
    logic [PPL_W-1:0] ppl_next, ppl_reg;
    logic [PPH_W-1:0] pph_next, pph_reg;
    logic dv_v_reg [Q_W+1];
    div_t dv_reg  [Q_W+1];
    div_t dv_next [Q_W+1];
    logic [REM_W-1:0] dsh;
    logic [Q_W-1:0] q_sel;
    out_t o_next, o_reg;

    // Threshold decision, lateral offset partial products and squared distance.
    always_comb begin
        thr = AW'({1'b0, cfg.turn_threshold, {ANG_SHIFT{1'b0}}});
        t1_next.to_base = in_data.to_base;
        t1_next.pos = in_data.to_base ? (in_data.err > thr) : (in_data.err >= thr);
        t1_next.neg = in_data.err < -thr;
        ax = in_data.dx[DIFF_W-1] ? MAG_W'(-in_data.dx) : MAG_W'(in_data.dx);
        ay = in_data.dy[DIFF_W-1] ? MAG_W'(-in_data.dy) : MAG_W'(in_data.dy);
        sqx_next = SQ_W'(ax) * SQ_W'(ax);
        sqy_next = SQ_W'(ay) * SQ_W'(ay);
        plo_next = PLO_W'(in_data.ly[LO_W-1:0]) * PLO_W'(KINV_Q29);
        phi_next = PHI_W'(signed'(in_data.ly[CW-1:LO_W]))
                 * PHI_W'(signed'({1'b0, KINV_Q29}));
    end

    always_comb begin
        prod = (PROD_W'(phi_reg) <<< LO_W) + PROD_W'(signed'({1'b0, plo_reg}));
        prod_sh = prod >>> KINV_SHIFT;
        lat_next = prod_sh[LAT_W-1:0];
        d_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    end

    always_comb begin
        lmag_next = lat_reg[LAT_W-1] ? LMAG_W'(-lat_reg) : LMAG_W'(lat_reg);
    end

    always_comb begin
        ppl_next = PPL_W'(cfg.max_speed) * PPL_W'(lmag_reg[LM_LO-1:0]);
        pph_next = PPH_W'(cfg.max_speed) * PPH_W'(lmag_reg[LMAG_W-1:LM_LO]);
    end

    // Restoring division, one quotient bit per stage from the top down.
    always_comb begin
        dv_next[0].turn    = t4_reg;
        dv_next[0].lat_neg = lneg4_reg;
        dv_next[0].d       = d4_reg;
        dv_next[0].dz      = d4_reg == '0;
        dv_next[0].big     = 1'b0;
        dv_next[0].q       = '0;
        dv_next[0].rem     = ((REM_W'(pph_reg) << LM_LO) + REM_W'(ppl_reg))
                             << (POS_FRAC_BITS + 1);
        for (int j = 0; j < Q_W; j++) begin
            dv_next[j+1] = dv_reg[j];
            dsh = REM_W'(dv_reg[j].d) << (Q_W - 1 - j);
            if (j == 0) begin
                dv_next[j+1].big = dv_reg[j].rem >= (REM_W'(dv_reg[j].d) << Q_W);
            end
            if (dv_reg[j].rem >= dsh) begin
                dv_next[j+1].rem = dv_reg[j].rem - dsh;
                dv_next[j+1].q[Q_W-1-j] = 1'b1;
            end
        end
    end

    always_comb begin
        q_sel = dv_reg[Q_W].big ? RATE_MAX : dv_reg[Q_W].q;
        o_next.going_to_base = dv_reg[Q_W].turn.to_base;
        if (dv_reg[Q_W].turn.pos || dv_reg[Q_W].turn.neg) begin
            o_next.linear_speed   = cfg.turn_speed;
            o_next.rate_saturated = 1'b0;
            if (dv_reg[Q_W].turn.pos) begin
                o_next.angular_rate = {1'b0, cfg.max_turn_rate};
                o_next.action       = ACT_HARD_POS;
            end else begin
                o_next.angular_rate = -{1'b0, cfg.max_turn_rate};
                o_next.action       = ACT_HARD_NEG;
            end
        end else begin
            o_next.linear_speed = cfg.max_speed;
            o_next.action       = ACT_PURSUIT;
            if (dv_reg[Q_W].dz) begin
                o_next.angular_rate   = {1'b0, RATE_MAX};
                o_next.rate_saturated = 1'b1;
            end else begin
                o_next.angular_rate   = dv_reg[Q_W].lat_neg ? -{1'b0, q_sel}
                                                           : {1'b0, q_sel};
                o_next.rate_saturated = dv_reg[Q_W].big;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int j = 0; j <= Q_W; j++) begin
                dv_v_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dv_v_reg[0] <= v4_reg;
            for (int j = 1; j <= Q_W; j++) begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
            vo_reg <= dv_v_reg[Q_W];
        end
        if (adv) begin
            t1_reg    <= t1_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            t2_reg    <= t1_reg;
            lat_reg   <= lat_next;
            d2_reg    <= d_next;
            t3_reg    <= t2_reg;
            d3_reg    <= d2_reg;
            lmag_reg  <= lmag_next;
            lneg3_reg <= lat_reg[LAT_W-1];
            t4_reg    <= t3_reg;
            d4_reg    <= d3_reg;
            lneg4_reg <= lneg3_reg;
            ppl_reg   <= ppl_next;
            pph_reg   <= pph_next;
            for (int j = 0; j <= Q_W; j++) begin
                dv_reg[j] <= dv_next[j];
            end
            o_reg <= o_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = o_reg;

endmodule

### sv/pps_check.sv
`timescale 1ns / 1ps
module pps_check (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input pps_pkg::out_t m_data,
    input logic          cfg_ready
);
    import pps_pkg::*;

    // A result beat waiting for the receiver keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // With nothing waiting at the output the block must take input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && cfg_ready)
        else $error("input refused with an empty output");

    // Hard turns never report a clipped rate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == ACT_HARD_POS || m_data.action == ACT_HARD_NEG)
        |-> !m_data.rate_saturated)
        else $error("saturation flagged on a hard turn");

    // A clipped pursuit rate sits at full scale of either sign.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == ACT_PURSUIT && m_data.rate_saturated
        |-> m_data.angular_rate == 32'h7FFFFFFF || m_data.angular_rate == 32'h80000001)
        else $error("saturated rate not at full scale");

endmodule

bind pure_pursuit_steering_top pps_check u_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);

### tb/pps_checker.sv
`timescale 1ns / 1ps
module pps_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  pps_pkg::in_t                  s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  pps_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pps_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            outstanding
);
    import pps_pkg::*;

    localparam longint PI_Q   = 64'sd3373259426;
    localparam longint HALF_Q = 64'sd1686629713;
    localparam longint TWO_Q  = 64'sd6746518852;
    localparam longint KINV_Q = 64'sd326016437;

    cfg_t shadow;
    out_t commands_due[$];
    int   mismatches;

    function automatic longint arctan_q30(int i);
        longint tbl [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tbl[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    function automatic logic [127:0] dist_sq(longint a, longint b);
        logic [127:0] ua, ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        return ua * ua + ub * ub;
    endfunction

    function automatic out_t steer_command(in_t it);
        longint ox, oy, tx, ty, bx, by, gx, gy, dx, dy, h;
        longint x, y, a, t, z, xs, ys, err, lat, thr;
        logic [127:0] tb_sq, d, n, q, ulat;
        logic [63:0] r2;
        bit to_base, pos_turn, neg_turn;
        out_t r;
        ox = it.own_x;    oy = it.own_y;
        tx = it.target_x; ty = it.target_y;
        bx = shadow.base_x; by = shadow.base_y;
        h = longint'(it.own_heading) <<< 17;
        tb_sq = dist_sq(tx - bx, ty - by);
        r2 = 64'(shadow.range_limit) * 64'(shadow.range_limit);
        to_base = tb_sq > {64'd0, r2};
        gx = to_base ? bx : tx;
        gy = to_base ? by : ty;
        dx = gx - ox;
        dy = gy - oy;
        if (h >= TWO_Q) h -= TWO_Q;
        if (h > PI_Q) h -= TWO_Q;

        // Rotate the goal offset into the body frame.
        x = dx; y = dy; a = -h;
        if (a > HALF_Q) begin
            t = x; x = -y; y = t; a -= HALF_Q;
        end else if (a < -HALF_Q) begin
            t = x; x = y; y = -t; a += HALF_Q;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (a >= 0) begin
                x = x - ys; y = y + xs; a -= arctan_q30(i);
            end else begin
                x = x + ys; y = y - xs; a += arctan_q30(i);
            end
        end
        lat = (y * KINV_Q) >>> 29;

        // Bearing of the rotated vector.
        if (x == 0 && y == 0) begin
            err = 0;
        end else begin
            z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = HALF_Q;
                end else begin
                    t = x; x = -y; y = t; z = -HALF_Q;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i; ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += arctan_q30(i);
                end else begin
                    x = x - ys; y = y + xs; z -= arctan_q30(i);
                end
            end
            err = z;
        end

        thr = longint'(shadow.turn_threshold) <<< 17;
        pos_turn = to_base ? (err > thr) : (err >= thr);
        neg_turn = err < -thr;
        r.going_to_base  = to_base;
        r.rate_saturated = 1'b0;
        if (pos_turn || neg_turn) begin
            r.linear_speed = shadow.turn_speed;
            r.angular_rate = pos_turn ? {1'b0, shadow.max_turn_rate}
                                      : -{1'b0, shadow.max_turn_rate};
            r.action = pos_turn ? ACT_HARD_POS : ACT_HARD_NEG;
        end else begin
            d = dist_sq(dx, dy);
            r.linear_speed = shadow.max_speed;
            r.action = ACT_PURSUIT;
            if (d == 0) begin
                r.angular_rate = 32'sh7FFF_FFFF;
                r.rate_saturated = 1'b1;
            end else begin
                ulat = (lat < 0) ? -lat : lat;
                n = (128'(shadow.max_speed) * ulat) << (POS_FRAC_BITS + 1);
                if (n >= (d << 31)) begin
                    q = 128'h7FFF_FFFF;
                    r.rate_saturated = 1'b1;
                end else begin
                    q = n / d;
                end
                r.angular_rate = (lat < 0) ? -q[31:0] : q[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            shadow = '0;
            commands_due.delete();
            mismatches = 0;
            fail_count <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_BASE_X:         shadow.base_x = cfg_data;
                    REG_BASE_Y:         shadow.base_y = cfg_data;
                    REG_RANGE_LIMIT:    shadow.range_limit = cfg_data;
                    REG_TURN_THRESHOLD: shadow.turn_threshold = cfg_data[THR_W-1:0];
                    REG_MAX_TURN_RATE:  shadow.max_turn_rate = cfg_data[30:0];
                    REG_MAX_SPEED:      shadow.max_speed = cfg_data;
                    REG_TURN_SPEED:     shadow.turn_speed = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                commands_due = {commands_due, steer_command(s_data)};
            if (m_valid && m_ready) begin
                if (commands_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: %p", m_data);
                end else begin
                    want = commands_due.pop_front();
                    if (want.linear_speed !== m_data.linear_speed
                        || want.angular_rate !== m_data.angular_rate
                        || want.action !== m_data.action
                        || want.going_to_base !== m_data.going_to_base
                        || want.rate_saturated !== m_data.rate_saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch at %0t: expected %p, got %p",
                                     $realtime, want, m_data);
                    end
                end
            end
            fail_count <= mismatches;
            outstanding <= commands_due.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 120;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic cfg_valid, cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    in_t  s_data;
    out_t m_data;
    int   fail_count, outstanding, cycles;
    bit   calm;

    pure_pursuit_steering_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pps_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stalls in bursts until the final phase.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && !calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(logic [31:0] bx, logic [31:0] by, logic [31:0] rl,
                               logic [31:0] thr, logic [31:0] mtr,
                               logic [31:0] spd, logic [31:0] tspd);
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
        write_reg(REG_RANGE_LIMIT, rl);
        write_reg(REG_TURN_THRESHOLD, thr);
        write_reg(REG_MAX_TURN_RATE, mtr);
        write_reg(REG_MAX_SPEED, spd);
        write_reg(REG_TURN_SPEED, tspd);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_fix(in_t it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] near(logic [31:0] c, int span);
        return c + $urandom_range(0, (32'd1 << span) - 1) - (32'd1 << (span - 1));
    endfunction

    function automatic in_t random_fix(logic [31:0] bx, logic [31:0] by);
        in_t it;
        int span;
        span = $urandom_range(4, 30);
        if ($urandom_range(0, 9) == 0) begin
            it.own_x       = $urandom;
            it.own_y       = $urandom;
            it.own_heading = 16'($urandom);
            it.target_x    = $urandom;
            it.target_y    = $urandom;
        end else begin
            it.own_x = near(bx, span);
            it.own_y = near(by, span);
            it.target_x = near(bx, $urandom_range(4, 30));
            it.target_y = near(by, $urandom_range(4, 30));
            it.own_heading = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 51471));
            if ($urandom_range(0, 19) == 0) begin
                it.target_x = it.own_x;
                it.target_y = it.own_y;
            end
        end
        return it;
    endfunction

    task automatic random_phase(int count, logic [31:0] bx, logic [31:0] by);
        repeat (count) send_fix(random_fix(bx, by));
        drain();
    endtask

    initial begin
        logic [31:0] bx, by;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        calm = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed beats with everything still at reset values.
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 0, target_y: 0});
        send_fix('{own_x: 32'h7FFF_FFFF, own_y: 32'h8000_0000, own_heading: 16'd51471,
                   target_x: 32'h8000_0000, target_y: 32'h7FFF_FFFF});
        drain();
        load_config(32'd0, 32'd0, 32'd1 << 24, 32'd6434, 32'd3 << 16,
                    32'd2 << 16, 32'd1 << 15);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        // Own at goal, in range and then out of range.
        send_fix('{own_x: 100, own_y: 200, own_heading: 0, target_x: 100, target_y: 200});
        send_fix('{own_x: 0, own_y: 0, own_heading: 100, target_x: 32'h7FFF_FFFF,
                   target_y: 32'h7FFF_FFFF});
        // Goal dead ahead, behind, left and right.
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 1 << 20, target_y: 0});
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: -(1 << 20), target_y: 0});
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 0, target_y: 1 << 20});
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 0, target_y: -(1 << 20)});
        // Headings at pi, just under 2pi and past it.
        send_fix('{own_x: 0, own_y: 0, own_heading: 16'd25736, target_x: 1 << 18,
                   target_y: 5});
        send_fix('{own_x: 0, own_y: 0, own_heading: 16'd51471, target_x: 1 << 18,
                   target_y: 3});
        send_fix('{own_x: 0, own_y: 0, own_heading: 16'hFFFF, target_x: 1 << 18,
                   target_y: 1 << 16});
        // Small lateral offsets that should stay below saturation.
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 1 << 22, target_y: 1 << 12});
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 4, target_y: 1});
        // Beyond the range, the base is the goal.
        send_fix('{own_x: 1 << 20, own_y: -(1 << 20), own_heading: 16'd12868,
                   target_x: 1 << 25, target_y: 0});
        drain();
        // Threshold past pi: never a hard turn.
        load_config(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: -(1 << 20), target_y: 1});
        send_fix('{own_x: 0, own_y: 0, own_heading: 0, target_x: 0, target_y: -(1 << 20)});
        send_fix('{own_x: 32'h8000_0000, own_y: 32'h8000_0000, own_heading: 0,
                   target_x: 32'h7FFF_FFFF, target_y: 32'h7FFF_FFFF});
        drain();

        // Threshold zero, range zero: extremes of the other direction.
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(100, 32'h7FFF_FFFF, 32'h8000_0000);

        repeat (4) begin
            bx = near(32'd0, $urandom_range(8, 31));
            by = near(32'd0, $urandom_range(8, 31));
            load_config(bx, by, $urandom >> $urandom_range(0, 12), $urandom_range(0, 25735),
                        $urandom, $urandom, $urandom);
            random_phase(130, bx, by);
        end

        // Closing phase without idling on either side.
        calm = 1'b1;
        bx = $urandom;
        by = $urandom;
        load_config(bx, by, 32'd1 << 26, 32'd25735, 32'h7FFF_FFFF, $urandom, $urandom);
        random_phase(110, bx, by);

        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### pure_pursuit_steering_top.f
sv/pps_pkg.sv
sv/pps_front.sv
sv/pps_cordic.sv
sv/pps_div.sv
sv/pure_pursuit_steering_top.sv
sv/pps_check.sv
tb/pps_checker.sv
tb/tb.sv
